>>> design/sofs_pkg.sv
// Shared types, constants and arithmetic helpers for the state observer step.
// Used by sofs_ctrl, sofs_dp, sofs_checker and state_observer_feedback_step.
// No dependencies.
package sofs_pkg;

  // Sizing
  localparam int MAX_MODES   = 8;
  localparam int COEF_W      = 18;
  localparam int STATE_W     = 32;
  localparam int DIM_MAX     = 2 * MAX_MODES;
  localparam int IDX_W       = $clog2(DIM_MAX);
  localparam int DIM_W       = $clog2(DIM_MAX + 1);
  localparam int CNT_W       = $clog2(DIM_MAX + 2);
  localparam int COEF_DEPTH  = DIM_MAX * (DIM_MAX + 4);
  localparam int ADDR_W      = $clog2(COEF_DEPTH);

  // Fixed field widths
  localparam int FRAC        = 16;
  localparam int SAMPLE_W    = 16;
  localparam int OUT_W       = 16;
  localparam int IN_COEF_W   = 18;
  localparam int CFG_W       = 4;
  localparam int MODES_RESET = 8;

  // Multiplier operand B holds state, error or the shifted sample
  localparam int B_W     = ((STATE_W > SAMPLE_W + FRAC) ? STATE_W : SAMPLE_W + FRAC) + 1;
  localparam int PROD_W  = COEF_W + B_W;
  localparam int ACC_W   = PROD_W + $clog2(DIM_MAX + 3);
  localparam int WIDE_W  = ACC_W + 2;

  // Stream packing
  localparam int IN_USER_W    = 2;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 32;
  localparam int TD_TBL_LSB   = 0;
  localparam int TD_ROW_LSB   = 3;
  localparam int TD_COL_LSB   = 7;
  localparam int TD_COEF_LSB  = 11;
  localparam int TD_SAMP_LSB  = 29;

  // Item commands
  localparam logic [1:0] CMD_PROCESS = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  // Coefficient tables
  localparam logic [2:0] TBL_TRANS = 3'd0;
  localparam logic [2:0] TBL_OBS   = 3'd1;
  localparam logic [2:0] TBL_INP   = 3'd2;
  localparam logic [2:0] TBL_FB    = 3'd3;
  localparam logic [2:0] TBL_OUT   = 3'd4;

  // Multiplier B operand source
  typedef enum logic [1:0] {
    B_STATE,
    B_ERR,
    B_SAMPLE
  } bsel_e;

  // Where a finished accumulation goes
  typedef enum logic [1:0] {
    D_ROW,
    D_DRIVE,
    D_PRED
  } dest_e;

  // One multiply-accumulate term issued by the controller
  typedef struct packed {
    logic              issue;
    logic              first;
    logic              last;
    bsel_e             bsel;
    dest_e             dest;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
  } mac_cmd_t;

  // Controller to datapath commands
  typedef struct packed {
    mac_cmd_t         mac;
    logic             coef_we;
    logic             clear;
    logic             start;
    logic             copy;
    logic [DIM_W-1:0] dim;
  } dp_cmd_t;

  // Tag that travels down the MAC pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    dest_e            dest;
    logic [IDX_W-1:0] row;
  } mac_tag_t;

  // Coefficient memory map: transition matrix, then the four vectors
  function automatic logic [ADDR_W-1:0] coef_addr(input logic [2:0] tbl,
                                                  input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    case (tbl)
      TBL_TRANS: coef_addr = ADDR_W'(row) * ADDR_W'(DIM_MAX) + ADDR_W'(col);
      TBL_OBS:   coef_addr = ADDR_W'(DIM_MAX * DIM_MAX) + ADDR_W'(row);
      TBL_INP:   coef_addr = ADDR_W'(DIM_MAX * (DIM_MAX + 1)) + ADDR_W'(row);
      TBL_FB:    coef_addr = ADDR_W'(DIM_MAX * (DIM_MAX + 2)) + ADDR_W'(row);
      TBL_OUT:   coef_addr = ADDR_W'(DIM_MAX * (DIM_MAX + 3)) + ADDR_W'(row);
      default:   coef_addr = '0;
    endcase
  endfunction

  // Round half up from Q.32 to Q.16, saturate to the state width
  function automatic logic signed [STATE_W-1:0] round_sat_state(
      input logic signed [ACC_W-1:0] acc);
    logic signed [WIDE_W-1:0] sum;
    logic signed [WIDE_W-1:0] sh;
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    sum = WIDE_W'(acc) + (WIDE_W'(1) <<< (FRAC - 1));
    sh  = sum >>> FRAC;
    hi  = (WIDE_W'(1) <<< (STATE_W - 1)) - WIDE_W'(1);
    lo  = ~hi;
    if (sh > hi) begin
      return hi[STATE_W-1:0];
    end else if (sh < lo) begin
      return lo[STATE_W-1:0];
    end
    return sh[STATE_W-1:0];
  endfunction

  // Negate, round half up from Q.32 to an integer, saturate to 16 bits
  function automatic logic signed [OUT_W-1:0] round_sat_drive(
      input logic signed [ACC_W-1:0] acc);
    logic signed [WIDE_W-1:0] sum;
    logic signed [WIDE_W-1:0] sh;
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    sum = -WIDE_W'(acc) + (WIDE_W'(1) <<< (2 * FRAC - 1));
    sh  = sum >>> (2 * FRAC);
    hi  = (WIDE_W'(1) <<< (OUT_W - 1)) - WIDE_W'(1);
    lo  = ~hi;
    if (sh > hi) begin
      return hi[OUT_W-1:0];
    end else if (sh < lo) begin
      return lo[OUT_W-1:0];
    end
    return sh[OUT_W-1:0];
  endfunction

  // Round a Q.16 prediction half up to an integer, saturate to 16 bits
  function automatic logic signed [OUT_W-1:0] round_sat_out(
      input logic signed [STATE_W-1:0] pred);
    logic signed [WIDE_W-1:0] sum;
    logic signed [WIDE_W-1:0] sh;
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    sum = WIDE_W'(pred) + (WIDE_W'(1) <<< (FRAC - 1));
    sh  = sum >>> FRAC;
    hi  = (WIDE_W'(1) <<< (OUT_W - 1)) - WIDE_W'(1);
    lo  = ~hi;
    if (sh > hi) begin
      return hi[OUT_W-1:0];
    end else if (sh < lo) begin
      return lo[OUT_W-1:0];
    end
    return sh[OUT_W-1:0];
  endfunction

endpackage

>>> design/sofs_ctrl.sv
// Sequencer for the observer step: input handshake, mode register and the
// MAC schedule over the coefficient memory. Depends on sofs_pkg.
module sofs_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [sofs_pkg::CFG_W-1:0] cfg_data_i,
  output logic                       cfg_ready_o,
  input  logic                       in_valid_i,
  input  logic [1:0]                 in_cmd_i,
  output logic                       in_ready_o,
  input  logic                       out_free_i,
  output logic                       load_out_o,
  output sofs_pkg::dp_cmd_t          cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_ROWS      = 7'b0000010,
    ST_ROW_DRAIN = 7'b0000100,
    ST_COPY      = 7'b0001000,
    ST_DOT       = 7'b0010000,
    ST_DOT_DRAIN = 7'b0100000,
    ST_DONE      = 7'b1000000
  } state_e;

  // Last drain count; the last issued term's result is stored as the drain ends
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  state_e                          state_q, state_d;
  logic [sofs_pkg::IDX_W-1:0]      row_q, row_d;
  logic [sofs_pkg::CNT_W-1:0]      term_q, term_d;
  logic                            pass_q, pass_d;
  logic [1:0]                      drain_q, drain_d;
  logic [sofs_pkg::CFG_W-1:0]      modes_q;
  logic [sofs_pkg::DIM_W-1:0]      dim;
  logic [sofs_pkg::CNT_W-1:0]      dim_cnt;
  logic                            row_is_last;

  // Mode register, written only while idle
  assign cfg_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modes_q <= sofs_pkg::CFG_W'(sofs_pkg::MODES_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      modes_q <= cfg_data_i;
    end
  end

  // Clamp the mode count and derive the active dimension
  always_comb begin
    if (modes_q == '0) begin
      dim = sofs_pkg::DIM_W'(2);
    end else if (int'(modes_q) > sofs_pkg::MAX_MODES) begin
      dim = sofs_pkg::DIM_W'(sofs_pkg::DIM_MAX);
    end else begin
      dim = sofs_pkg::DIM_W'({modes_q, 1'b0});
    end
  end

  assign dim_cnt     = sofs_pkg::CNT_W'(dim);
  assign row_is_last = (sofs_pkg::DIM_W'(row_q) == dim - sofs_pkg::DIM_W'(1));

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    term_d     = term_q;
    pass_d     = pass_q;
    drain_d    = drain_q;
    in_ready_o = 1'b0;
    load_out_o = 1'b0;
    cmd_o      = '0;
    cmd_o.dim  = dim;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_cmd_i)
            sofs_pkg::CMD_PROCESS: begin
              cmd_o.start = 1'b1;
              row_d       = '0;
              term_d      = '0;
              state_d     = ST_ROWS;
            end
            sofs_pkg::CMD_WRITE: cmd_o.coef_we = 1'b1;
            sofs_pkg::CMD_CLEAR: cmd_o.clear   = 1'b1;
            default: ;
          endcase
        end
      end

      // One state row: matrix terms, then observer gain, then input gain
      ST_ROWS: begin
        cmd_o.mac.issue = 1'b1;
        cmd_o.mac.first = (term_q == '0);
        cmd_o.mac.dest  = sofs_pkg::D_ROW;
        cmd_o.mac.row   = row_q;
        cmd_o.mac.idx   = term_q[sofs_pkg::IDX_W-1:0];
        if (term_q < dim_cnt) begin
          cmd_o.mac.bsel = sofs_pkg::B_STATE;
          cmd_o.mac.addr = sofs_pkg::coef_addr(sofs_pkg::TBL_TRANS, row_q,
                                               term_q[sofs_pkg::IDX_W-1:0]);
          term_d = term_q + sofs_pkg::CNT_W'(1);
        end else if (term_q == dim_cnt) begin
          cmd_o.mac.bsel = sofs_pkg::B_ERR;
          cmd_o.mac.addr = sofs_pkg::coef_addr(sofs_pkg::TBL_OBS, row_q, '0);
          term_d = term_q + sofs_pkg::CNT_W'(1);
        end else begin
          cmd_o.mac.bsel = sofs_pkg::B_SAMPLE;
          cmd_o.mac.last = 1'b1;
          cmd_o.mac.addr = sofs_pkg::coef_addr(sofs_pkg::TBL_INP, row_q, '0);
          term_d = '0;
          if (row_is_last) begin
            drain_d = '0;
            state_d = ST_ROW_DRAIN;
          end else begin
            row_d = row_q + sofs_pkg::IDX_W'(1);
          end
        end
      end

      ST_ROW_DRAIN: begin
        drain_d = drain_q + 2'd1;
        if (drain_q == DRAIN_LAST) begin
          state_d = ST_COPY;
        end
      end

      ST_COPY: begin
        cmd_o.copy = 1'b1;
        term_d     = '0;
        pass_d     = 1'b0;
        state_d    = ST_DOT;
      end

      // Feedback dot product, then output dot product, on the new state
      ST_DOT: begin
        cmd_o.mac.issue = 1'b1;
        cmd_o.mac.first = (term_q == '0);
        cmd_o.mac.last  = (term_q == dim_cnt - sofs_pkg::CNT_W'(1));
        cmd_o.mac.bsel  = sofs_pkg::B_STATE;
        cmd_o.mac.dest  = pass_q ? sofs_pkg::D_PRED : sofs_pkg::D_DRIVE;
        cmd_o.mac.idx   = term_q[sofs_pkg::IDX_W-1:0];
        cmd_o.mac.addr  = sofs_pkg::coef_addr(pass_q ? sofs_pkg::TBL_OUT : sofs_pkg::TBL_FB,
                                              term_q[sofs_pkg::IDX_W-1:0], '0);
        if (cmd_o.mac.last) begin
          term_d = '0;
          if (pass_q) begin
            drain_d = '0;
            state_d = ST_DOT_DRAIN;
          end else begin
            pass_d = 1'b1;
          end
        end else begin
          term_d = term_q + sofs_pkg::CNT_W'(1);
        end
      end

      ST_DOT_DRAIN: begin
        drain_d = drain_q + 2'd1;
        if (drain_q == DRAIN_LAST) begin
          state_d = ST_DONE;
        end
      end

      // Hand the result to the output register once it has room
      ST_DONE: begin
        if (out_free_i) begin
          load_out_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      term_q  <= '0;
      pass_q  <= 1'b0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      term_q  <= term_d;
      pass_q  <= pass_d;
      drain_q <= drain_d;
    end
  end

endmodule

>>> design/sofs_dp.sv
// Datapath for the observer step: coefficient memory, state registers,
// shared multiply-accumulate pipeline and result rounding. Depends on sofs_pkg.
module sofs_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sofs_pkg::dp_cmd_t                     cmd_i,
  input  logic [2:0]                            coef_table_i,
  input  logic [3:0]                            coef_row_i,
  input  logic [3:0]                            coef_col_i,
  input  logic signed [sofs_pkg::IN_COEF_W-1:0] coef_value_i,
  input  logic signed [sofs_pkg::SAMPLE_W-1:0]  sample_i,
  output logic signed [sofs_pkg::OUT_W-1:0]     drive_o,
  output logic signed [sofs_pkg::OUT_W-1:0]     predicted_o
);

  logic signed [sofs_pkg::COEF_W-1:0]  coef_mem_q [sofs_pkg::COEF_DEPTH];
  logic signed [sofs_pkg::COEF_W-1:0]  coef_rd_q;
  logic signed [sofs_pkg::COEF_W-1:0]  coef_wdata;
  logic [sofs_pkg::ADDR_W-1:0]         coef_waddr;
  logic                                coef_row_ok;
  logic                                coef_col_ok;
  logic                                coef_tbl_ok;
  logic                                coef_we;

  logic signed [sofs_pkg::STATE_W-1:0] state_q [sofs_pkg::DIM_MAX];
  logic signed [sofs_pkg::STATE_W-1:0] next_q  [sofs_pkg::DIM_MAX];
  logic signed [sofs_pkg::STATE_W-1:0] prediction_q;
  logic signed [sofs_pkg::B_W-1:0]     samp_sh_d, samp_sh_q;
  logic signed [sofs_pkg::B_W-1:0]     err_d, err_q;
  logic signed [sofs_pkg::B_W-1:0]     b_d, b_q;
  logic signed [sofs_pkg::PROD_W-1:0]  prod_q;
  logic signed [sofs_pkg::ACC_W-1:0]   acc_q;
  logic signed [sofs_pkg::OUT_W-1:0]   drive_q;
  sofs_pkg::mac_tag_t                  s1_q, s2_q;
  logic                                fin_q;
  sofs_pkg::dest_e                     fin_dest_q;
  logic [sofs_pkg::IDX_W-1:0]          fin_row_q;

  // Coefficient write: drop out-of-storage indices and unknown tables
  assign coef_row_ok = (int'(coef_row_i) < sofs_pkg::DIM_MAX);
  assign coef_col_ok = (int'(coef_col_i) < sofs_pkg::DIM_MAX);
  assign coef_tbl_ok = (coef_table_i == sofs_pkg::TBL_TRANS) ? coef_col_ok
                                                             : (coef_table_i <= sofs_pkg::TBL_OUT);
  assign coef_we     = cmd_i.coef_we && coef_row_ok && coef_tbl_ok;
  assign coef_waddr  = sofs_pkg::coef_addr(coef_table_i,
                                           sofs_pkg::IDX_W'(coef_row_i),
                                           sofs_pkg::IDX_W'(coef_col_i));
  assign coef_wdata  = sofs_pkg::COEF_W'(coef_value_i);

  // Coefficient memory with registered read
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem_q[coef_waddr] <= coef_wdata;
    end
    coef_rd_q <= coef_mem_q[cmd_i.mac.addr];
  end

  // Error and shifted sample, captured when a process item starts
  assign samp_sh_d = sofs_pkg::B_W'(sample_i) <<< sofs_pkg::FRAC;
  assign err_d     = samp_sh_d - sofs_pkg::B_W'(prediction_q);

  // Select the B operand for the issued term
  always_comb begin
    case (cmd_i.mac.bsel)
      sofs_pkg::B_STATE:  b_d = sofs_pkg::B_W'(state_q[cmd_i.mac.idx]);
      sofs_pkg::B_ERR:    b_d = err_q;
      sofs_pkg::B_SAMPLE: b_d = samp_sh_q;
      default:            b_d = '0;
    endcase
  end

  // Payload: operand, product, accumulator, row buffer, drive
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      samp_sh_q <= samp_sh_d;
      err_q     <= err_d;
    end
    b_q    <= b_d;
    prod_q <= coef_rd_q * b_q;
    if (s2_q.valid) begin
      acc_q <= s2_q.first ? sofs_pkg::ACC_W'(prod_q)
                          : acc_q + sofs_pkg::ACC_W'(prod_q);
    end
    fin_dest_q <= s2_q.dest;
    fin_row_q  <= s2_q.row;
    if (fin_q) begin
      case (fin_dest_q)
        sofs_pkg::D_ROW:   next_q[fin_row_q] <= sofs_pkg::round_sat_state(acc_q);
        sofs_pkg::D_DRIVE: drive_q <= sofs_pkg::round_sat_drive(acc_q);
        default: ;
      endcase
    end
  end

  // Pipeline tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      s2_q  <= '0;
      fin_q <= 1'b0;
    end else begin
      s1_q.valid <= cmd_i.mac.issue;
      s1_q.first <= cmd_i.mac.first;
      s1_q.last  <= cmd_i.mac.last;
      s1_q.dest  <= cmd_i.mac.dest;
      s1_q.row   <= cmd_i.mac.row;
      s2_q       <= s1_q;
      fin_q      <= s2_q.valid && s2_q.last;
    end
  end

  // Plant state: clear, or copy the active rows from the row buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < sofs_pkg::DIM_MAX; k++) begin
        state_q[k] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int k = 0; k < sofs_pkg::DIM_MAX; k++) begin
        state_q[k] <= '0;
      end
    end else if (cmd_i.copy) begin
      for (int k = 0; k < sofs_pkg::DIM_MAX; k++) begin
        if (sofs_pkg::DIM_W'(k) < cmd_i.dim) begin
          state_q[k] <= next_q[k];
        end
      end
    end
  end

  // Prediction: clear, or take the finished output dot product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prediction_q <= '0;
    end else if (cmd_i.clear) begin
      prediction_q <= '0;
    end else if (fin_q && fin_dest_q == sofs_pkg::D_PRED) begin
      prediction_q <= sofs_pkg::round_sat_state(acc_q);
    end
  end

  assign drive_o     = drive_q;
  assign predicted_o = sofs_pkg::round_sat_out(prediction_q);

endmodule

>>> design/state_observer_feedback_step.sv
// Top level of the state observer step: stream unpacking, output register,
// and the sofs_ctrl / sofs_dp pair. Depends on sofs_pkg, sofs_ctrl, sofs_dp.
//
//   Channel  Dir  Handshake                    Payload
//   s_axis   in   s_axis_tvalid/s_axis_tready  tuser command, tdata table..sample
//   m_axis   out  m_axis_tvalid/m_axis_tready  tdata drive, predicted
//   cfg      in   cfg_valid_i/cfg_ready_o      cfg_data_i modes_in_use, taken while idle
//
// Write, clear and unknown items finish on their transfer and leave the input open. A
// process item closes the input after its transfer while it runs, D = 2 * modes_in_use:
// D*(D+2) state terms and 2*D output terms on one shared multiplier, two drains, a copy
// and a hand-off. Reset clears control, plant state and prediction, not the coefficients.
// A stalled m_axis holds the result in the output register and holds the block in its
// hand-off state until that register has room.
module state_observer_feedback_step (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command, tuser[1:0]
  input  logic [sofs_pkg::IN_USER_W-1:0]      s_axis_tuser,
  // coef_table[2:0], coef_row[6:3], coef_col[10:7], coef_value[28:11],
  // sample[44:29], zero[47:45]
  input  logic [sofs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // drive[15:0], predicted[31:16]
  output logic [sofs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [sofs_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o
);

  sofs_pkg::dp_cmd_t                     cmd;
  logic                                  out_free;
  logic                                  load_out;
  logic signed [sofs_pkg::OUT_W-1:0]     drive;
  logic signed [sofs_pkg::OUT_W-1:0]     predicted;
  logic                                  m_valid_q;
  logic [sofs_pkg::OUT_TDATA_W-1:0]      m_data_q;

  // Output register has room when empty or being drained this cycle
  assign out_free = !m_valid_q || m_axis_tready;

  sofs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_free_i  (out_free),
    .load_out_o  (load_out),
    .cmd_o       (cmd)
  );

  sofs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .coef_table_i (s_axis_tdata[sofs_pkg::TD_TBL_LSB +: 3]),
    .coef_row_i   (s_axis_tdata[sofs_pkg::TD_ROW_LSB +: 4]),
    .coef_col_i   (s_axis_tdata[sofs_pkg::TD_COL_LSB +: 4]),
    .coef_value_i (s_axis_tdata[sofs_pkg::TD_COEF_LSB +: sofs_pkg::IN_COEF_W]),
    .sample_i     (s_axis_tdata[sofs_pkg::TD_SAMP_LSB +: sofs_pkg::SAMPLE_W]),
    .drive_o      (drive),
    .predicted_o  (predicted)
  );

  // Output register: load a finished result, drop it after the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {predicted, drive};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> design/sofs_checker.sv
// Port-level checks for state_observer_feedback_step, bound to the top level.
// Depends on sofs_pkg.
module sofs_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [sofs_pkg::IN_USER_W-1:0]      s_axis_tuser,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [sofs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready
);

  // A process transfer starts the sequence, so input closes next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == sofs_pkg::CMD_PROCESS)
    |=> !s_axis_tready)
    else $error("input still open after a process transfer");

  // Any other transfer finishes at once and leaves the input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser != sofs_pkg::CMD_PROCESS)
    |=> s_axis_tready)
    else $error("input closed after a write or clear transfer");

  // A new result appears only at the end of a busy sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result raised while the block was idle");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result dropped or changed");

endmodule

bind state_observer_feedback_step sofs_checker u_sofs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
